// File: hdl/pdr_pkg.sv
`default_nettype none
package pdr_pkg;

	localparam int MAX_LEN = 4096;
	localparam int DEPTH   = MAX_LEN + 1;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int PW      = 28;
	localparam int PROB_W  = 17;
	localparam int POS_W   = 13;
	localparam int CFG_IDX_W = 2;

	localparam logic [PW-1:0] PREFIX_MAX = {PW{1'b1}};

	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EDGE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTI   = 2'd2;

	localparam logic [PROB_W-1:0] TRIGGER_RST = 17'd16384;
	localparam logic [PROB_W-1:0] EDGE_RST    = 17'd6554;
	localparam logic [PROB_W-1:0] MULTI_RST   = 17'd13107;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_SCAN,
		ST_OUT
	} pdr_state_t;

	typedef enum logic [1:0] {
		SC_IDLE,
		SC_BASE,
		SC_PAIR,
		SC_DRAIN
	} pdr_scan_phase_t;

	typedef struct packed {
		logic              go;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		logic [PW-1:0]     end_hi;
	} pdr_scan_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] b_addr;
		logic [ADDR_W-1:0] e_addr;
	} pdr_rd_req_t;

	typedef struct packed {
		logic done;
		logic multi;
	} pdr_scan_sts_t;

endpackage
`default_nettype wire

// File: hdl/pdr_ram.sv
`default_nettype none
module pdr_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 4097,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/pdr_scan.sv
`default_nettype none
module pdr_scan (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pdr_pkg::pdr_scan_cmd_t        cmd,
	input  wire logic [pdr_pkg::PROB_W-1:0]    multi_thr,
	output pdr_pkg::pdr_rd_req_t               rd,
	input  wire logic [pdr_pkg::PW-1:0]        b_rdata,
	input  wire logic [pdr_pkg::PW-1:0]        e_rdata,
	output pdr_pkg::pdr_scan_sts_t             sts
);

	pdr_pkg::pdr_scan_phase_t phase_q, phase_d;

	logic [pdr_pkg::ADDR_W-1:0] z_q;
	logic [pdr_pkg::ADDR_W-1:0] hi_q;
	logic [pdr_pkg::PW-1:0]     ehi_q;
	logic [pdr_pkg::PW-1:0]     base_q;
	logic                       flag_q;
	logic                       base_s1;
	logic                       pair_s1;
	logic                       zero_s1;

	logic [pdr_pkg::PW-1:0] thr_ext;
	logic [pdr_pkg::PW-1:0] e_val;
	logic [pdr_pkg::PW-1:0] b_val;
	logic                   hit;

	always_comb begin
		phase_d = phase_q;
		rd      = '0;
		case (phase_q)
			pdr_pkg::SC_IDLE: begin
				if (cmd.go) begin
					phase_d = pdr_pkg::SC_BASE;
				end
			end
			pdr_pkg::SC_BASE: begin
				rd.en     = 1'b1;
				rd.b_addr = z_q - pdr_pkg::ADDR_W'(1);
				phase_d   = pdr_pkg::SC_PAIR;
			end
			pdr_pkg::SC_PAIR: begin
				rd.en     = 1'b1;
				rd.e_addr = z_q - pdr_pkg::ADDR_W'(1);
				rd.b_addr = z_q;
				if (z_q == hi_q) begin
					phase_d = pdr_pkg::SC_DRAIN;
				end
			end
			pdr_pkg::SC_DRAIN: begin
				phase_d = pdr_pkg::SC_IDLE;
			end
			default: begin
				phase_d = pdr_pkg::SC_IDLE;
			end
		endcase
	end

	// index zero of both prefix stores reads as zero
	assign thr_ext = pdr_pkg::PW'(multi_thr);
	assign e_val   = ehi_q - (zero_s1 ? '0 : e_rdata);
	assign b_val   = b_rdata - base_q;
	assign hit     = pair_s1 && (e_val >= thr_ext) && (b_val >= thr_ext);

	assign sts.done  = (phase_q == pdr_pkg::SC_DRAIN);
	assign sts.multi = flag_q | hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= pdr_pkg::SC_IDLE;
			flag_q  <= 1'b0;
			base_s1 <= 1'b0;
			pair_s1 <= 1'b0;
		end else begin
			phase_q <= phase_d;
			base_s1 <= (phase_q == pdr_pkg::SC_BASE);
			pair_s1 <= (phase_q == pdr_pkg::SC_PAIR);
			if (phase_q == pdr_pkg::SC_IDLE && cmd.go) begin
				flag_q <= 1'b0;
			end else begin
				flag_q <= flag_q | hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= (z_q == pdr_pkg::ADDR_W'(1));
		if (phase_q == pdr_pkg::SC_IDLE && cmd.go) begin
			z_q   <= cmd.lo;
			hi_q  <= cmd.hi;
			ehi_q <= cmd.end_hi;
		end else if (phase_q == pdr_pkg::SC_PAIR) begin
			z_q <= z_q + pdr_pkg::ADDR_W'(1);
		end
		if (base_s1) begin
			base_q <= zero_s1 ? '0 : b_rdata;
		end
	end

endmodule
`default_nettype wire

// File: hdl/posterior_domain_region_detector_top.sv
// channel  | handshake                   | payload
// ---------+-----------------------------+-------------------------------------------
// input    | in_valid / in_ready         | seq_start, occupancy, begin_prob, end_prob
// output   | out_valid / out_ready       | region_start, region_end, multidomain
// config   | cfg_we (no wait)            | cfg_index, cfg_data
//
// an item that closes no region is accepted, then goes through prefix update and edge tests
// an item that closes a region adds a split scan over the two prefix memories,
// one split point per cycle, then waits for a free output register
// reset clears control state only; no clearing pass, index zero of the prefix stores reads as zero
// a finished item waits in the output register while the next item is accepted
`default_nettype none
module posterior_domain_region_detector_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [pdr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pdr_pkg::PROB_W-1:0]        cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              seq_start,
	input  wire logic [pdr_pkg::PROB_W-1:0]        occupancy,
	input  wire logic [pdr_pkg::PROB_W-1:0]        begin_prob,
	input  wire logic [pdr_pkg::PROB_W-1:0]        end_prob,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [pdr_pkg::POS_W-1:0]              region_start,
	output logic [pdr_pkg::POS_W-1:0]              region_end,
	output logic                                   multidomain
);

	localparam int AW = pdr_pkg::ADDR_W;
	localparam int PW = pdr_pkg::PW;
	localparam int QW = pdr_pkg::PROB_W;

	pdr_pkg::pdr_state_t state_q, state_d;

	logic [QW-1:0] trig_thr_q;
	logic [QW-1:0] edge_thr_q;
	logic [QW-1:0] multi_thr_q;

	logic          seqs_q;
	logic [QW-1:0] occ_q;
	logic [QW-1:0] bp_q;
	logic [QW-1:0] ep_q;

	logic [AW-1:0] pos_q;
	logic          trig_q;
	logic          sv_q;
	logic [AW-1:0] sp_q;
	logic [PW-1:0] lastb_q;
	logic [PW-1:0] laste_q;

	logic [AW-1:0] lo_q;
	logic [AW-1:0] hi_q;
	logic          md_q;

	logic                  out_valid_q;
	logic [pdr_pkg::POS_W-1:0] rs_q;
	logic [pdr_pkg::POS_W-1:0] re_q;
	logic                  mdo_q;

	logic [AW-1:0] pos_eff;
	logic          trig_eff;
	logic          sv_eff;
	logic [AW-1:0] sp_eff;
	logic [PW-1:0] lastb_eff;
	logic [PW-1:0] laste_eff;
	logic          ignore;
	logic [AW-1:0] idx;
	logic [PW:0]   bsum;
	logic [PW:0]   esum;
	logic [PW-1:0] nb;
	logic [PW-1:0] ne;
	logic [QW-1:0] bdelta;
	logic [QW-1:0] edelta;
	logic          b_fail;
	logic          e_fail;
	logic [AW-1:0] s_fix;
	logic          trig_n;
	logic          sv_n;
	logic [AW-1:0] sp_n;
	logic          close;
	logic          slot_free;
	logic          mem_we;

	pdr_pkg::pdr_scan_cmd_t scan_cmd;
	pdr_pkg::pdr_rd_req_t   rd_req;
	pdr_pkg::pdr_scan_sts_t scan_sts;
	logic [PW-1:0]          b_rdata;
	logic [PW-1:0]          e_rdata;

	// per-item datapath, state of a new sequence applied first
	always_comb begin
		pos_eff   = seqs_q ? '0 : pos_q;
		trig_eff  = seqs_q ? 1'b0 : trig_q;
		sv_eff    = seqs_q ? 1'b0 : sv_q;
		sp_eff    = seqs_q ? '0 : sp_q;
		lastb_eff = seqs_q ? '0 : lastb_q;
		laste_eff = seqs_q ? '0 : laste_q;
		ignore    = (pos_eff >= AW'(pdr_pkg::MAX_LEN));
		idx       = pos_eff + AW'(1);

		bsum   = {1'b0, lastb_eff} + (PW+1)'(bp_q);
		esum   = {1'b0, laste_eff} + (PW+1)'(ep_q);
		nb     = bsum[PW] ? pdr_pkg::PREFIX_MAX : bsum[PW-1:0];
		ne     = esum[PW] ? pdr_pkg::PREFIX_MAX : esum[PW-1:0];
		bdelta = QW'(nb - lastb_eff);
		edelta = QW'(ne - laste_eff);
		b_fail = ((QW+1)'(occ_q) < ((QW+1)'(edge_thr_q) + (QW+1)'(bdelta)));
		e_fail = ((QW+1)'(occ_q) < ((QW+1)'(edge_thr_q) + (QW+1)'(edelta)));

		s_fix = (sp_eff == '0 || sp_eff > idx) ? idx : sp_eff;

		trig_n = trig_eff;
		sv_n   = sv_eff;
		sp_n   = sp_eff;
		close  = 1'b0;
		if (!ignore) begin
			if (!trig_eff) begin
				if (b_fail) begin
					sv_n = 1'b0;
				end else if (!sv_eff) begin
					sv_n = 1'b1;
					sp_n = idx;
				end
				if (occ_q >= trig_thr_q) begin
					trig_n = 1'b1;
					if (!sv_n) begin
						sv_n = 1'b1;
						sp_n = idx;
					end
				end
			end else if (e_fail) begin
				close  = 1'b1;
				trig_n = 1'b0;
				sv_n   = 1'b0;
			end
		end
	end

	assign slot_free = !out_valid_q || out_ready;
	assign mem_we    = (state_q == pdr_pkg::ST_CALC) && !ignore;

	always_comb begin
		state_d = state_q;
		case (state_q)
			pdr_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pdr_pkg::ST_CALC;
				end
			end
			pdr_pkg::ST_CALC: begin
				state_d = close ? pdr_pkg::ST_SCAN : pdr_pkg::ST_IDLE;
			end
			pdr_pkg::ST_SCAN: begin
				if (scan_sts.done) begin
					state_d = pdr_pkg::ST_OUT;
				end
			end
			pdr_pkg::ST_OUT: begin
				if (slot_free) begin
					state_d = pdr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pdr_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_ready = (state_q == pdr_pkg::ST_IDLE);

	assign scan_cmd.go     = (state_q == pdr_pkg::ST_CALC) && close;
	assign scan_cmd.lo     = s_fix;
	assign scan_cmd.hi     = idx;
	assign scan_cmd.end_hi = ne;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdr_pkg::ST_IDLE;
			trig_thr_q  <= pdr_pkg::TRIGGER_RST;
			edge_thr_q  <= pdr_pkg::EDGE_RST;
			multi_thr_q <= pdr_pkg::MULTI_RST;
			pos_q       <= '0;
			trig_q      <= 1'b0;
			sv_q        <= 1'b0;
			sp_q        <= '0;
			lastb_q     <= '0;
			laste_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					pdr_pkg::CFG_TRIGGER: trig_thr_q  <= cfg_data;
					pdr_pkg::CFG_EDGE:    edge_thr_q  <= cfg_data;
					pdr_pkg::CFG_MULTI:   multi_thr_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (state_q == pdr_pkg::ST_CALC) begin
				pos_q   <= ignore ? pos_eff : idx;
				trig_q  <= trig_n;
				sv_q    <= sv_n;
				sp_q    <= sp_n;
				lastb_q <= ignore ? lastb_eff : nb;
				laste_q <= ignore ? laste_eff : ne;
			end
			if (state_q == pdr_pkg::ST_OUT && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			seqs_q <= seq_start;
			occ_q  <= occupancy;
			bp_q   <= begin_prob;
			ep_q   <= end_prob;
		end
		if (scan_cmd.go) begin
			lo_q <= s_fix;
			hi_q <= idx;
		end
		if (state_q == pdr_pkg::ST_SCAN && scan_sts.done) begin
			md_q <= scan_sts.multi;
		end
		if (state_q == pdr_pkg::ST_OUT && slot_free) begin
			rs_q  <= pdr_pkg::POS_W'(lo_q);
			re_q  <= pdr_pkg::POS_W'(hi_q);
			mdo_q <= md_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign region_start = rs_q;
	assign region_end   = re_q;
	assign multidomain  = mdo_q;

	pdr_ram #(
		.WIDTH (PW),
		.DEPTH (pdr_pkg::DEPTH),
		.AW    (AW)
	) u_begin_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx),
		.wdata (nb),
		.re    (rd_req.en),
		.raddr (rd_req.b_addr),
		.rdata (b_rdata)
	);

	pdr_ram #(
		.WIDTH (PW),
		.DEPTH (pdr_pkg::DEPTH),
		.AW    (AW)
	) u_end_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (idx),
		.wdata (ne),
		.re    (rd_req.en),
		.raddr (rd_req.e_addr),
		.rdata (e_rdata)
	);

	pdr_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (scan_cmd),
		.multi_thr (multi_thr_q),
		.rd        (rd_req),
		.b_rdata   (b_rdata),
		.e_rdata   (e_rdata),
		.sts       (scan_sts)
	);

endmodule
`default_nettype wire
